// ===== sv/wireworld_grid_engine_macros.svh =====
// Assertion shorthands shared by the RTL
`ifndef WIREWORLD_GRID_ENGINE_MACROS_SVH
`define WIREWORLD_GRID_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define WW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define WW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ww_pkg.sv =====
`timescale 1ns / 1ps

package ww_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  typedef logic [1:0] cell_t;

  localparam cell_t CELL_EMPTY = 2'd0;
  localparam cell_t CELL_HEAD  = 2'd1;
  localparam cell_t CELL_TAIL  = 2'd2;
  localparam cell_t CELL_WIRE  = 2'd3;

  localparam logic [1:0] FN_WRITE = 2'd0;
  localparam logic [1:0] FN_READ  = 2'd1;
  localparam logic [1:0] FN_GEN   = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] row;
    logic [5:0] col;
    cell_t      cell_value;
  } in_word_t;

  typedef struct packed {
    cell_t read_value;
    logic  changed;
    logic  out_of_range;
  } out_word_t;

  // Sequencer state
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GEN,
    ST_FLUSH
  } ww_state_t;

  // Per-column control handed from the sequencer to the cell unit
  typedef struct packed {
    logic valid;
    logic first_col;
    logic pad;
    logic top;
    logic bottom;
  } col_ctl_t;

endpackage

// ===== sv/ww_grid_mem.sv =====
`timescale 1ns / 1ps

module ww_grid_mem #(
  parameter int AW = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  ww_pkg::cell_t     wdata,
  input  logic [AW-1:0]     raddr0,
  input  logic [AW-1:0]     raddr1,
  output ww_pkg::cell_t     rdata0,
  output ww_pkg::cell_t     rdata1
);

  localparam int DEPTH = 1 << AW;

  ww_pkg::cell_t mem_r [DEPTH];
  ww_pkg::cell_t rdata0_r;
  ww_pkg::cell_t rdata1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata0_r <= mem_r[raddr0];
    rdata1_r <= mem_r[raddr1];
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

// ===== sv/ww_row_buf.sv =====
`timescale 1ns / 1ps

module ww_row_buf #(
  parameter int CW = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [CW-1:0]     waddr,
  input  ww_pkg::cell_t     wdata,
  input  logic [CW-1:0]     raddr,
  output ww_pkg::cell_t     rdata
);

  localparam int DEPTH = 1 << CW;

  ww_pkg::cell_t buf_r [DEPTH];
  ww_pkg::cell_t rdata_r;

  // read-first: a read and a write at one address return the old cell
  always_ff @(posedge clk) begin
    if (we) begin
      buf_r[waddr] <= wdata;
    end
    rdata_r <= buf_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ww_cell_unit.sv =====
`timescale 1ns / 1ps

module ww_cell_unit (
  input  logic              clk,
  input  ww_pkg::col_ctl_t  ctl,
  input  ww_pkg::cell_t     above_d,
  input  ww_pkg::cell_t     cur_d,
  input  ww_pkg::cell_t     below_d,
  output logic              wr_en,
  output ww_pkg::cell_t     wr_val,
  output logic              new_head
);

  // index 2 above, 1 current row, 0 below
  ww_pkg::cell_t [2:0] left_r;
  ww_pkg::cell_t [2:0] mid_r;
  ww_pkg::cell_t [2:0] left_nxt;
  ww_pkg::cell_t [2:0] mid_nxt;
  ww_pkg::cell_t [2:0] fresh;
  logic [3:0]          heads;

  always_comb begin
    fresh[2] = (ctl.pad || ctl.top)    ? ww_pkg::CELL_EMPTY : above_d;
    fresh[1] = ctl.pad                 ? ww_pkg::CELL_EMPTY : cur_d;
    fresh[0] = (ctl.pad || ctl.bottom) ? ww_pkg::CELL_EMPTY : below_d;
  end

  // Eight neighbors of the middle column's center cell
  always_comb begin
    heads = 4'(left_r[2] == ww_pkg::CELL_HEAD) + 4'(left_r[1] == ww_pkg::CELL_HEAD)
          + 4'(left_r[0] == ww_pkg::CELL_HEAD) + 4'(mid_r[2] == ww_pkg::CELL_HEAD)
          + 4'(mid_r[0] == ww_pkg::CELL_HEAD) + 4'(fresh[2] == ww_pkg::CELL_HEAD)
          + 4'(fresh[1] == ww_pkg::CELL_HEAD) + 4'(fresh[0] == ww_pkg::CELL_HEAD);
  end

  always_comb begin
    wr_en    = ctl.valid && !ctl.first_col;
    new_head = 1'b0;
    unique case (mid_r[1])
      ww_pkg::CELL_HEAD: wr_val = ww_pkg::CELL_TAIL;
      ww_pkg::CELL_TAIL: wr_val = ww_pkg::CELL_WIRE;
      ww_pkg::CELL_WIRE: begin
        if (heads == 4'd1 || heads == 4'd2) begin
          wr_val   = ww_pkg::CELL_HEAD;
          new_head = wr_en;
        end else begin
          wr_val = ww_pkg::CELL_WIRE;
        end
      end
      default: wr_val = ww_pkg::CELL_EMPTY;
    endcase
  end

  // Shift the window; a new row starts with an empty column on the left
  always_comb begin
    left_nxt = left_r;
    mid_nxt  = mid_r;
    if (ctl.valid) begin
      left_nxt = ctl.first_col ? {3{ww_pkg::CELL_EMPTY}} : mid_r;
      mid_nxt  = fresh;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    mid_r  <= mid_nxt;
  end

endmodule

// ===== sv/wireworld_grid_engine.sv =====
`timescale 1ns / 1ps
// Wireworld grid engine. A write or read is taken in any cycle where busy is
// low and its result strobes on out_valid in the next cycle, so writes and
// reads run one per cycle. A generation raises busy while it sweeps the grid
// and strobes its result in the first cycle where busy is low again: one rule
// unit visits one column of the 3x3 window per cycle, fed by the two read
// ports of the grid memory and a buffer holding the old row above, plus one
// padding column per row. After reset the grid memory is cleared one cell per
// cycle, with busy high; configuration writes are taken throughout. Results
// cannot be stalled: out_valid lasts exactly one cycle.

`include "wireworld_grid_engine_macros.svh"

module wireworld_grid_engine #(
  parameter int MAX_ROWS = ww_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = ww_pkg::MAX_COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  ww_pkg::in_word_t               in_word,
  output logic                           out_valid,
  output ww_pkg::out_word_t              out_word,
  input  logic                           cfg_we,
  input  logic [ww_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ww_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int RNW = $clog2(MAX_ROWS + 1);
  localparam int CNW = $clog2(MAX_COLS + 1);
  localparam int AW  = RW + CW;

  ww_pkg::ww_state_t        state_r, state_nxt;
  logic [AW-1:0]            clr_addr_r, clr_addr_nxt;
  logic [ww_pkg::CFG_W-1:0] rows_cfg_r, cols_cfg_r;
  logic [RNW-1:0]           used_rows;
  logic [CNW-1:0]           used_cols;

  logic [RW-1:0]            a_row_r, a_row_nxt;
  logic [CNW-1:0]           a_col_r, a_col_nxt;
  logic                     changed_r, changed_nxt;

  logic                     b_vld_r;
  logic [RW-1:0]            b_row_r;
  logic [CNW-1:0]           b_col_r;
  logic                     b_pad_r, b_top_r, b_bot_r;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_rd_r, out_rd_nxt;
  logic                     out_chg_r, out_chg_nxt;
  logic                     out_oor_r, out_oor_nxt;

  logic                     acc;
  logic                     in_rng;
  logic                     a_last_row;

  logic                     grid_we;
  logic [AW-1:0]            grid_waddr;
  ww_pkg::cell_t            grid_wdata;
  logic [AW-1:0]            grid_raddr0, grid_raddr1;
  ww_pkg::cell_t            grid_rdata0, grid_rdata1;
  ww_pkg::cell_t            above_rdata;

  ww_pkg::col_ctl_t         cu_ctl;
  logic                     cu_wr_en;
  ww_pkg::cell_t            cu_wr_val;
  logic                     cu_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= ww_pkg::CFG_W'(64);
      cols_cfg_r <= ww_pkg::CFG_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ww_pkg::REG_ROWS: rows_cfg_r <= cfg_wdata;
        ww_pkg::REG_COLS: cols_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    used_rows = (32'(rows_cfg_r) > 32'(MAX_ROWS)) ? RNW'(MAX_ROWS) : RNW'(rows_cfg_r);
    used_cols = (32'(cols_cfg_r) > 32'(MAX_COLS)) ? CNW'(MAX_COLS) : CNW'(cols_cfg_r);
  end

  assign busy       = (state_r != ww_pkg::ST_IDLE);
  assign acc        = start && !busy;
  assign in_rng     = (32'(in_word.row) < 32'(used_rows)) && (32'(in_word.col) < 32'(used_cols));
  assign a_last_row = (32'(a_row_r) + 32'd1) >= 32'(used_rows);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    a_row_nxt     = a_row_r;
    a_col_nxt     = a_col_r;
    changed_nxt   = changed_r;
    out_valid_nxt = 1'b0;
    out_rd_nxt    = 1'b0;
    out_chg_nxt   = 1'b0;
    out_oor_nxt   = 1'b0;
    unique case (state_r)
      ww_pkg::ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          state_nxt = ww_pkg::ST_IDLE;
        end
      end
      ww_pkg::ST_IDLE: begin
        if (acc) begin
          priority if (in_word.func == ww_pkg::FN_WRITE || in_word.func == ww_pkg::FN_READ) begin
            out_valid_nxt = 1'b1;
            out_oor_nxt   = !in_rng;
            out_rd_nxt    = (in_word.func == ww_pkg::FN_READ) && in_rng;
          end else if (in_word.func == ww_pkg::FN_GEN) begin
            if (used_rows == '0 || used_cols == '0) begin
              out_valid_nxt = 1'b1;
            end else begin
              state_nxt   = ww_pkg::ST_GEN;
              a_row_nxt   = '0;
              a_col_nxt   = '0;
              changed_nxt = 1'b0;
            end
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ww_pkg::ST_GEN: begin
        changed_nxt = changed_r | cu_head;
        if (a_col_r == used_cols) begin
          if (a_last_row) begin
            state_nxt = ww_pkg::ST_FLUSH;
          end else begin
            a_row_nxt = a_row_r + 1'b1;
            a_col_nxt = '0;
          end
        end else begin
          a_col_nxt = a_col_r + 1'b1;
        end
      end
      ww_pkg::ST_FLUSH: begin
        state_nxt     = ww_pkg::ST_IDLE;
        out_valid_nxt = 1'b1;
        out_chg_nxt   = changed_r | cu_head;
      end
      default: state_nxt = ww_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ww_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      b_vld_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      b_vld_r     <= (state_r == ww_pkg::ST_GEN);
    end
  end

  always_ff @(posedge clk) begin
    a_row_r   <= a_row_nxt;
    a_col_r   <= a_col_nxt;
    changed_r <= changed_nxt;
    out_rd_r  <= out_rd_nxt;
    out_chg_r <= out_chg_nxt;
    out_oor_r <= out_oor_nxt;
    b_row_r   <= a_row_r;
    b_col_r   <= a_col_r;
    b_pad_r   <= (a_col_r == used_cols);
    b_top_r   <= (a_row_r == '0);
    b_bot_r   <= a_last_row;
  end

  // Grid ports: clear sweep, then generation write-back, then item writes
  always_comb begin
    grid_we    = 1'b0;
    grid_waddr = '0;
    grid_wdata = ww_pkg::CELL_EMPTY;
    priority if (state_r == ww_pkg::ST_CLEAR) begin
      grid_we    = 1'b1;
      grid_waddr = clr_addr_r;
    end else if (cu_wr_en) begin
      grid_we    = 1'b1;
      grid_waddr = {b_row_r, CW'(b_col_r - CNW'(1))};
      grid_wdata = cu_wr_val;
    end else if (acc && in_word.func == ww_pkg::FN_WRITE && in_rng) begin
      grid_we    = 1'b1;
      grid_waddr = {RW'(in_word.row), CW'(in_word.col)};
      grid_wdata = in_word.cell_value;
    end else begin
      grid_we = 1'b0;
    end
  end

  always_comb begin
    if (state_r == ww_pkg::ST_IDLE) begin
      grid_raddr0 = {RW'(in_word.row), CW'(in_word.col)};
    end else begin
      grid_raddr0 = {a_row_r, CW'(a_col_r)};
    end
    grid_raddr1 = {RW'(a_row_r + 1'b1), CW'(a_col_r)};
  end

  ww_grid_mem #(
    .AW (AW)
  ) u_grid (
    .clk    (clk),
    .we     (grid_we),
    .waddr  (grid_waddr),
    .wdata  (grid_wdata),
    .raddr0 (grid_raddr0),
    .raddr1 (grid_raddr1),
    .rdata0 (grid_rdata0),
    .rdata1 (grid_rdata1)
  );

  // Keep the old current row for use as the row above on the next pass
  ww_row_buf #(
    .CW (CW)
  ) u_above (
    .clk   (clk),
    .we    (b_vld_r && !b_pad_r),
    .waddr (CW'(b_col_r)),
    .wdata (grid_rdata0),
    .raddr (CW'(a_col_r)),
    .rdata (above_rdata)
  );

  always_comb begin
    cu_ctl.valid     = b_vld_r;
    cu_ctl.first_col = (b_col_r == '0);
    cu_ctl.pad       = b_pad_r;
    cu_ctl.top       = b_top_r;
    cu_ctl.bottom    = b_bot_r;
  end

  ww_cell_unit u_cell (
    .clk      (clk),
    .ctl      (cu_ctl),
    .above_d  (above_rdata),
    .cur_d    (grid_rdata0),
    .below_d  (grid_rdata1),
    .wr_en    (cu_wr_en),
    .wr_val   (cu_wr_val),
    .new_head (cu_head)
  );

  assign out_valid               = out_valid_r;
  assign out_word.read_value     = out_rd_r ? grid_rdata0 : ww_pkg::CELL_EMPTY;
  assign out_word.changed        = out_chg_r;
  assign out_word.out_of_range   = out_oor_r;

  `WW_ASSERT_NEXT(a_rw_result, acc && in_word.func != ww_pkg::FN_GEN && !(in_word.func == ww_pkg::FN_GEN), out_valid, "write/read/idle op gave no result word")
  `WW_ASSERT_NOW(a_flags_excl, out_valid, !(out_word.changed && out_word.out_of_range), "changed and out_of_range both set")
  `WW_ASSERT_NOW(a_wb_behind, (state_r == ww_pkg::ST_GEN) && b_vld_r && (b_row_r == a_row_r), b_col_r < a_col_r, "write-back not behind read column")
  `WW_ASSERT_NOW(a_clear_quiet, state_r == ww_pkg::ST_CLEAR, !out_valid && !cu_wr_en, "activity during clear sweep")
  `WW_ASSERT_NEXT(a_gen_busy, acc && in_word.func == ww_pkg::FN_GEN && used_rows != '0 && used_cols != '0, busy && !out_valid, "generation did not hold busy")

endmodule
